[rtl/core/feistel_block_cipher_8_round_unit_assert.svh]
// Assertion macros for the checker module of the Feistel cipher unit.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef FEISTEL_BLOCK_CIPHER_8_ROUND_UNIT_ASSERT_SVH
`define FEISTEL_BLOCK_CIPHER_8_ROUND_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside of reset.
`define FBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside of reset.
`define FBC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checked at every edge, reset included.
`define FBC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/fbc_pkg.sv]
// Shared types, constants and the round function of the Feistel cipher unit.
// Used by every module of the unit; depends on nothing.
package fbc_pkg;

   localparam int unsigned NUM_ROUNDS     = 8;
   localparam int unsigned KEY_COUNT      = 8;
   localparam int unsigned KEY_W          = 32;
   localparam int unsigned KEY_IDX_W      = $clog2(KEY_COUNT);
   localparam int unsigned CSR_IDX_W      = KEY_IDX_W + 1;
   localparam int unsigned BLOCK_W        = 64;
   localparam int unsigned HALF_W         = BLOCK_W / 2;
   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned BYTES_PER_HALF = HALF_W / BYTE_W;

   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [KEY_COUNT-1:0][KEY_W-1:0] key_bank_type;

   typedef struct packed {
      logic               decrypt;
      logic [BLOCK_W-1:0] block;
   } fbc_item_type;

   // Byte-wise product of the half and the key, keeping the low byte of each.
   function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] half,
                                                 input logic [KEY_W-1:0]  key);
      logic [HALF_W-1:0]   f;
      logic [2*BYTE_W-1:0] prod;
      f = '0;
      for (int i = 0; i < BYTES_PER_HALF; i++) begin
         prod = half[i*BYTE_W +: BYTE_W] * key[i*BYTE_W +: BYTE_W];
         f[i*BYTE_W +: BYTE_W] = prod[BYTE_W-1:0];
      end
      return f;
   endfunction

endpackage

[rtl/core/fbc_front.sv]
// Request front end of the Feistel cipher unit: decodes the direction and
// buffers requests in a short queue. Depends on fbc_pkg.
module fbc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [fbc_pkg::BLOCK_W-1:0] req_block_in,
   output logic                   q_valid,
   input  logic                   q_ready,
   output fbc_pkg::fbc_item_type  q_item
);

   fbc_pkg::fbc_item_type       mem_ff [fbc_pkg::QUEUE_DEPTH];
   fbc_pkg::fbc_item_type       wr_item;
   logic [fbc_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [fbc_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [fbc_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        push;
   logic                        pop;

   assign req_ready = (count_ff != fbc_pkg::QCNT_W'(fbc_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];
   assign push      = req_valid & req_ready;
   assign pop       = q_valid & q_ready;

   always_comb begin
      wr_item.decrypt = (req_opcode == fbc_pkg::OP_DECRYPT);
      wr_item.block   = req_block_in;

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fbc_pkg::QPTR_W'(fbc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fbc_pkg::QPTR_W'(fbc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

[rtl/core/fbc_round_pipe.sv]
// Back end of the Feistel cipher unit: one pipeline stage per round, the last
// stage doubling as the response register. Depends on fbc_pkg.
module fbc_round_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  fbc_pkg::fbc_item_type        q_item,
   input  fbc_pkg::key_bank_type        keys,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fbc_pkg::BLOCK_W-1:0]  rsp_block_out
);

   localparam int unsigned N = fbc_pkg::NUM_ROUNDS;
   localparam int unsigned H = fbc_pkg::HALF_W;

   logic [N-1:0] vld_ff;
   logic [N-1:0] stg_ready;
   logic [H-1:0] left_ff  [N];
   logic [H-1:0] right_ff [N];
   logic         dec_ff   [N];

   // A stage takes new data when it is empty or its content moves on.
   always_comb begin
      for (int s = 0; s < N; s++) begin
         if (s == N - 1) begin
            stg_ready[s] = !vld_ff[s] | rsp_ready;
         end else begin
            stg_ready[s] = !vld_ff[s] | stg_ready[s+1];
         end
      end
   end

   assign q_ready = stg_ready[0];

   for (genvar s = 0; s < N; s++) begin : g_round
      localparam int unsigned FWD = s;
      localparam int unsigned REV = N - 1 - s;

      logic                      vld_in;
      logic                      dec_in;
      logic [H-1:0]              left_src;
      logic [H-1:0]              right_src;
      logic [fbc_pkg::KEY_W-1:0] key;

      if (s == 0) begin : g_first
         assign vld_in    = q_valid;
         assign dec_in    = q_item.decrypt;
         assign left_src  = q_item.block[fbc_pkg::BLOCK_W-1:H];
         assign right_src = q_item.block[H-1:0];
      end else begin : g_next
         assign vld_in    = vld_ff[s-1];
         assign dec_in    = dec_ff[s-1];
         assign left_src  = left_ff[s-1];
         assign right_src = right_ff[s-1];
      end

      assign key = dec_in ? keys[REV] : keys[FWD];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (stg_ready[s]) begin
            vld_ff[s] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (stg_ready[s]) begin
            dec_ff[s]   <= dec_in;
            left_ff[s]  <= right_src;
            right_ff[s] <= left_src ^ fbc_pkg::round_f(right_src, key);
         end
      end
   end

   assign rsp_valid     = vld_ff[N-1];
   assign rsp_block_out = {right_ff[N-1], left_ff[N-1]};

endmodule

[rtl/core/feistel_block_cipher_8_round_unit.sv]
// Top level of the 64-bit, eight-round Feistel cipher unit.
// Depends on fbc_pkg, fbc_front and fbc_round_pipe.
//
// Usage:
//   Request channel (req_valid/req_ready) carries req_opcode (0 encrypt,
//   1 decrypt) and the 64-bit block req_block_in. Response channel
//   (rsp_valid/rsp_ready) returns rsp_block_out, one response per request,
//   in request order.
//   Round keys are written through csr_we/csr_index/csr_wdata; indexes 0..7
//   select round_key_0..7, any other index is ignored. Write keys only while
//   no request is in flight.
//   Throughput is one request per cycle: the round pipeline has one stage per
//   round, each with four 8x8 byte multipliers, and an empty stage takes new data.
//   An accepted request is written into the request queue, then registered
//   once in each round stage; the last stage drives the response channel.
//   Reset empties the queue and the pipeline and clears all round keys to zero.
//   When rsp_ready is low the last stage holds and the stages before it fill;
//   the four-entry queue keeps taking requests until full, then req_ready drops.
module feistel_block_cipher_8_round_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [fbc_pkg::BLOCK_W-1:0]    req_block_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [fbc_pkg::BLOCK_W-1:0]    rsp_block_out,
   input  logic                           csr_we,
   input  logic [fbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbc_pkg::KEY_W-1:0]      csr_wdata
);

   fbc_pkg::key_bank_type  key_ff;
   fbc_pkg::fbc_item_type  q_item;
   logic                   q_valid;
   logic                   q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_we && (csr_index < fbc_pkg::CSR_IDX_W'(fbc_pkg::KEY_COUNT))) begin
         key_ff[csr_index[fbc_pkg::KEY_IDX_W-1:0]] <= csr_wdata;
      end
   end

   fbc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_block_in (req_block_in),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_item       (q_item)
   );

   fbc_round_pipe u_pipe (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_item        (q_item),
      .keys          (key_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_block_out (rsp_block_out)
   );

endmodule

[rtl/core/fbc_checker.sv]
// Port-level checker for the Feistel cipher unit, bound to its top level.
// Depends on fbc_pkg and the assertion macro header.
`include "feistel_block_cipher_8_round_unit_assert.svh"

module fbc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [fbc_pkg::BLOCK_W-1:0] rsp_block_out
);

   // After reset the pipeline is empty and the queue has room.
   `FBC_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready, "not empty after reset")

   // The queue can only fill up behind a completely stalled pipeline.
   `FBC_ASSERT_SAME(a_full_means_stall, clock, reset, !req_ready, rsp_valid, "queue full without response")

   `FBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

   `FBC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_block_out), "response changed")

endmodule

bind feistel_block_cipher_8_round_unit fbc_checker u_fbc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_block_out (rsp_block_out)
);

[test/tb_feistel_block_cipher_8_round_unit.sv]
// Self-checking testbench for the eight-round Feistel cipher unit.
// Needs fbc_pkg and feistel_block_cipher_8_round_unit; blocks are predicted here
// and compared with every response in order.
module tb_feistel_block_cipher_8_round_unit;

   localparam logic [fbc_pkg::CSR_IDX_W-1:0] CSR_ROUND_KEY_0 = '0;
   localparam int unsigned CSR_UNMAPPED_FIRST  = fbc_pkg::KEY_COUNT;
   localparam int unsigned CSR_INDEX_COUNT     = 1 << fbc_pkg::CSR_IDX_W;
   localparam int unsigned IDLE_CYCLE_LIMIT    = 5000;
   localparam int unsigned ERRORS_SHOWN        = 10;
   localparam int unsigned BACKPRESSURE_CYCLES = 300;
   localparam int unsigned PHASE_REQUESTS      = 240;

   typedef struct packed {
      logic [fbc_pkg::BLOCK_W-1:0] block_out;
   } cipher_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_opcode;
   logic [fbc_pkg::BLOCK_W-1:0]   req_block_in;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [fbc_pkg::BLOCK_W-1:0]   rsp_block_out;
   logic                          csr_we;
   logic [fbc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fbc_pkg::KEY_W-1:0]     csr_wdata;

   fbc_pkg::key_bank_type         key_shadow;
   cipher_result_type             expected_blocks[$];
   cipher_result_type             oldest_block;
   int unsigned                   error_count;
   int unsigned                   idle_cycles;
   int unsigned                   rsp_hold_request;
   bit                            req_gaps_on;
   bit                            rsp_stalls_on;

   feistel_block_cipher_8_round_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_block_out (rsp_block_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Byte-wise product of a half with a key; only the low byte of each product survives.
   function automatic logic [fbc_pkg::HALF_W-1:0] byte_mix(
         input logic [fbc_pkg::HALF_W-1:0] half,
         input logic [fbc_pkg::KEY_W-1:0]  key);
      logic [fbc_pkg::HALF_W-1:0] mixed;
      logic [fbc_pkg::BYTE_W-1:0] lo;
      mixed = '0;
      for (int b = 0; b < fbc_pkg::BYTES_PER_HALF; b++) begin
         lo = half[b*fbc_pkg::BYTE_W +: fbc_pkg::BYTE_W] *
              key[b*fbc_pkg::BYTE_W +: fbc_pkg::BYTE_W];
         mixed[b*fbc_pkg::BYTE_W +: fbc_pkg::BYTE_W] = lo;
      end
      return mixed;
   endfunction

   function automatic cipher_result_type cipher_block(input fbc_pkg::fbc_item_type item);
      cipher_result_type          result;
      logic [fbc_pkg::HALF_W-1:0] lhalf;
      logic [fbc_pkg::HALF_W-1:0] rhalf;
      logic [fbc_pkg::HALF_W-1:0] nxt;
      int unsigned                k;
      lhalf = item.block[fbc_pkg::BLOCK_W-1:fbc_pkg::HALF_W];
      rhalf = item.block[fbc_pkg::HALF_W-1:0];
      for (int r = 0; r < fbc_pkg::NUM_ROUNDS; r++) begin
         k = (item.decrypt == fbc_pkg::OP_DECRYPT) ? fbc_pkg::NUM_ROUNDS - 1 - r : r;
         if (k >= fbc_pkg::KEY_COUNT) k = fbc_pkg::KEY_COUNT - 1;
         nxt = lhalf ^ byte_mix(rhalf, key_shadow[k]);
         lhalf = rhalf;
         rhalf = nxt;
      end
      result.block_out = {rhalf, lhalf};
      return result;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_idle_length(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic logic [fbc_pkg::BYTE_W-1:0] pick_edge_byte();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h01;
         default: return fbc_pkg::BYTE_W'($urandom);
      endcase
   endfunction

   function automatic logic [fbc_pkg::BLOCK_W-1:0] pick_block();
      logic [fbc_pkg::BLOCK_W-1:0] blk;
      blk = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
         for (int b = 0; b < fbc_pkg::BLOCK_W / fbc_pkg::BYTE_W; b++)
            blk[b*fbc_pkg::BYTE_W +: fbc_pkg::BYTE_W] = pick_edge_byte();
      end
      return blk;
   endfunction

   function automatic logic [fbc_pkg::KEY_W-1:0] pick_key();
      logic [fbc_pkg::KEY_W-1:0] key;
      int roll;
      roll = $urandom_range(0, 99);
      key = $urandom;
      if (roll < 12) key = '0;
      else if (roll < 24) key = '1;
      else if (roll < 34) begin
         for (int b = 0; b < fbc_pkg::BYTES_PER_HALF; b++)
            key[b*fbc_pkg::BYTE_W +: fbc_pkg::BYTE_W] = pick_edge_byte();
      end
      return key;
   endfunction

   function automatic logic pick_opcode();
      return ($urandom_range(0, 1) != 0) ? fbc_pkg::OP_DECRYPT : fbc_pkg::OP_ENCRYPT;
   endfunction

   // Offers one request and returns at the edge where it is taken.
   task automatic send_request(input logic op, input logic [fbc_pkg::BLOCK_W-1:0] blk);
      int                    gap;
      fbc_pkg::fbc_item_type item;
      gap = pick_idle_length(req_gaps_on);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_block_in <= blk;
      do @(posedge clock); while (!(req_valid && req_ready));
      item.decrypt = op;
      item.block   = blk;
      expected_blocks.push_back(cipher_block(item));
   endtask

   task automatic release_request_bus();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_csr(input logic [fbc_pkg::CSR_IDX_W-1:0] index,
                            input logic [fbc_pkg::KEY_W-1:0]     data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index - CSR_ROUND_KEY_0 < fbc_pkg::KEY_COUNT)
         key_shadow[index - CSR_ROUND_KEY_0] = data;
   endtask

   task automatic load_key_bank(input fbc_pkg::key_bank_type bank);
      for (int i = 0; i < fbc_pkg::KEY_COUNT; i++)
         write_csr(fbc_pkg::CSR_IDX_W'(CSR_ROUND_KEY_0 + i), bank[i]);
   endtask

   // Keys may only change with nothing in flight.
   task automatic drain_pipeline();
      release_request_bus();
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (fbc_pkg::NUM_ROUNDS + 1) @(posedge clock);
   endtask

   // Keys still hold their reset value of zero, so every round is a plain swap.
   task automatic test_zero_keys();
      send_request(fbc_pkg::OP_ENCRYPT, '0);
      send_request(fbc_pkg::OP_ENCRYPT, '1);
      send_request(fbc_pkg::OP_DECRYPT, 64'h0123_4567_89AB_CDEF);
      send_request(fbc_pkg::OP_DECRYPT, '1);
      drain_pipeline();
   endtask

   task automatic test_key_overflow();
      fbc_pkg::key_bank_type bank;
      for (int i = 0; i < fbc_pkg::KEY_COUNT; i++) bank[i] = '1;
      load_key_bank(bank);
      send_request(fbc_pkg::OP_ENCRYPT, '0);
      send_request(fbc_pkg::OP_ENCRYPT, '1);
      send_request(fbc_pkg::OP_DECRYPT, '1);
      send_request(fbc_pkg::OP_ENCRYPT, 64'h8080_8080_8080_8080);
      send_request(fbc_pkg::OP_DECRYPT, 64'h0101_0101_FFFF_FFFF);
      send_request(fbc_pkg::OP_ENCRYPT, 64'hAAAA_AAAA_5555_5555);
      drain_pipeline();
   endtask

   // Distinct keys per round and distinct bytes within each key expose any ordering
   // slip; a decrypt of a predicted ciphertext must give the plaintext back.
   task automatic test_byte_order_and_round_trip();
      fbc_pkg::key_bank_type bank;
      fbc_pkg::fbc_item_type plain;
      cipher_result_type     sealed;
      for (int i = 0; i < fbc_pkg::KEY_COUNT; i++)
         bank[i] = {8'(4*i + 3), 8'(4*i + 5), 8'(4*i + 7), 8'(4*i + 9)};
      load_key_bank(bank);
      send_request(fbc_pkg::OP_ENCRYPT, 64'h0102_0304_0506_0708);
      send_request(fbc_pkg::OP_DECRYPT, 64'h0102_0304_0506_0708);
      send_request(fbc_pkg::OP_ENCRYPT, 64'hFF00_0000_0000_00FF);
      plain.decrypt = fbc_pkg::OP_ENCRYPT;
      plain.block   = 64'hDEAD_BEEF_0BAD_F00D;
      sealed = cipher_block(plain);
      send_request(fbc_pkg::OP_ENCRYPT, plain.block);
      send_request(fbc_pkg::OP_DECRYPT, sealed.block_out);
      drain_pipeline();
   endtask

   // Writes to indexes past the last key must leave every key untouched.
   task automatic test_unmapped_index();
      for (int i = CSR_UNMAPPED_FIRST; i < CSR_INDEX_COUNT; i++)
         write_csr(fbc_pkg::CSR_IDX_W'(i), $urandom);
      send_request(fbc_pkg::OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      send_request(fbc_pkg::OP_DECRYPT, 64'hFEDC_BA98_7654_3210);
      drain_pipeline();
   endtask

   task automatic test_random_traffic();
      fbc_pkg::key_bank_type bank;
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < fbc_pkg::KEY_COUNT; i++) bank[i] = pick_key();
         load_key_bank(bank);
         req_gaps_on   = (phase == 0) || (phase == 2);
         rsp_stalls_on = (phase == 0) || (phase == 3);
         repeat (PHASE_REQUESTS) send_request(pick_opcode(), pick_block());
         drain_pipeline();
      end
   endtask

   // The response side holds off long enough for the queue and pipeline to fill.
   task automatic test_input_backpressure();
      req_gaps_on      = 1'b0;
      rsp_stalls_on    = 1'b0;
      rsp_hold_request = BACKPRESSURE_CYCLES;
      repeat (40) send_request(pick_opcode(), pick_block());
      rsp_stalls_on = 1'b1;
      req_gaps_on   = 1'b1;
      repeat (20) send_request(pick_opcode(), pick_block());
      drain_pipeline();
   endtask

   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request != 0) begin
            stall_left       = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0) begin
            stall_left = pick_idle_length(rsp_stalls_on);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            error_count++;
            if (error_count <= ERRORS_SHOWN)
               $display("unexpected response: block_out %h", rsp_block_out);
         end else begin
            oldest_block = expected_blocks.pop_front();
            if (rsp_block_out !== oldest_block.block_out) begin
               error_count++;
               if (error_count <= ERRORS_SHOWN)
                  $display("mismatch: block_out expected %h got %h",
                           oldest_block.block_out, rsp_block_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_CYCLE_LIMIT) begin
         $display("[feistel_block_cipher_8_round_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = fbc_pkg::OP_ENCRYPT;
      req_block_in     = '0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      key_shadow       = '0;
      error_count      = 0;
      idle_cycles      = 0;
      rsp_hold_request = 0;
      req_gaps_on      = 1'b0;
      rsp_stalls_on    = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_keys();
      test_key_overflow();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      test_byte_order_and_round_trip();
      test_unmapped_index();
      test_random_traffic();
      test_input_backpressure();

      repeat (fbc_pkg::NUM_ROUNDS + 4) @(posedge clock);
      if (error_count == 0 && expected_blocks.size() == 0) begin
         $display("[feistel_block_cipher_8_round_unit] OK");
      end else begin
         $display("[feistel_block_cipher_8_round_unit] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/fbc_pkg.sv
rtl/core/fbc_front.sv
rtl/core/fbc_round_pipe.sv
rtl/core/feistel_block_cipher_8_round_unit.sv
rtl/core/fbc_checker.sv
test/tb_feistel_block_cipher_8_round_unit.sv
